// File: src/scratchpad_memory_with_atomics_core_assert.svh
// ----------------------------------------------------------------------------
// scratchpad assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SCRATCHPAD_MEMORY_WITH_ATOMICS_CORE_ASSERT_SVH
`define SCRATCHPAD_MEMORY_WITH_ATOMICS_CORE_ASSERT_SVH

// same-cycle implication
`define SPM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("scratchpad assertion failed");

// next-cycle implication
`define SPM_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("scratchpad assertion failed");

`endif

// File: src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// request codes, defaults and shared types of the scratchpad
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int WORD_W  = 32;
  localparam int MODE_W  = 4;
  localparam int CHAN_W  = 8;

  localparam int ADDR_BITS_DEF  = 18;
  localparam int LINE_BYTES_DEF = 32;
  localparam int EOP_BIT_DEF    = 0;

  localparam logic [MODE_W-1:0] MODE_LDW   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LDH   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_LDB   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STW   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_STH   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_STB   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FETCH = 4'd6;
  localparam logic [MODE_W-1:0] MODE_FILL  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ADD   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_OR    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_AND   = 4'd10;
  localparam logic [MODE_W-1:0] MODE_XOR   = 4'd11;
  localparam logic [MODE_W-1:0] MODE_XCHG  = 4'd12;

  // outcome of one read-modify-write step
  typedef struct packed {
    logic              we;
    logic              reply;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;
  } merge_t;

endpackage

// File: src/scratchpad_memory_with_atomics_core.sv
// ----------------------------------------------------------------------------
// scratchpad_memory_with_atomics_core
// word scratchpad with loads, stores, atomics, packet fetch and line fill
// ----------------------------------------------------------------------------
// usage
//   a request transfer happens at a rising edge with start_i high and busy_o
//   low; mode_i, address_i, write_data_i and return_channel_i are sampled then
//   replies appear on read_data_o, reply_channel_o and last_o for exactly one
//   cycle with valid_o high; the receiver has no way to stall them
//   sequence per mode, all set by the single port of the word ram:
//     stw: a single write, no reply
//     ldw/ldh/ldb, sth/stb, atomics: a read, then merge and write back for
//       stores and atomics; a reply is registered from the merge step
//     packet fetch: n replies, one word read per cycle
//     line fill: LINE_BYTES/4 words, one word written per cycle
//     no-op and unused modes: no reply
//   busy_o stays high while a request is in flight, so accesses to one word
//   never overlap and no forwarding is needed
//   reset clears the sequencer and the reply strobe only; the word ram holds
//   nothing defined until written and gets no clearing pass
// ----------------------------------------------------------------------------
`include "scratchpad_memory_with_atomics_core_assert.svh"

module scratchpad_memory_with_atomics_core import spm_pkg::*; #(
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int EOP_BIT    = EOP_BIT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [WORD_W-1:0]    write_data_i,
  input  logic [CHAN_W-1:0]    return_channel_i,
  output logic                 valid_o,
  output logic [WORD_W-1:0]    read_data_o,
  output logic [CHAN_W-1:0]    reply_channel_o,
  output logic                 last_o
);

  // word index width, line geometry
  localparam int IW    = ADDR_BITS - 2;
  localparam int DEPTH = 2 ** IW;
  localparam int LW    = LINE_BYTES / 4;
  localparam int LWB   = $clog2(LW);
  localparam int PW    = (IW > LWB) ? IW : LWB;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RMW   = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [1:0]        lane_q;
  logic [IW-1:0]     widx_q;
  logic [WORD_W-1:0] data_q;
  logic [CHAN_W-1:0] chan_q;
  logic [LWB-1:0]    pos_q, pos_d;

  // reply register
  logic              valid_q, valid_d;
  logic [WORD_W-1:0] rdata_q, rdata_d;
  logic              last_q, last_d;
  logic [CHAN_W-1:0] rchan_q;

  // ram port
  logic              ram_en;
  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              accept;
  logic [IW-1:0]     in_widx;
  logic [PW-1:0]     in_ext;
  logic [PW-1:0]     base_ext;
  logic [PW-1:0]     line_ext;
  logic [PW-1:0]     next_ext;
  logic [LWB-1:0]    pos_inc;
  logic              pos_end;
  logic              fetch_fin;
  merge_t            mrg;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign in_widx  = address_i[ADDR_BITS-1:2];
  assign in_ext   = PW'(in_widx);

  // aligned line base; the line may wrap over the whole store when small
  assign base_ext = PW'(widx_q) & ~PW'(LW - 1);
  assign line_ext = base_ext | PW'(pos_q);
  assign pos_inc  = pos_q + 1'b1;
  assign next_ext = base_ext | PW'(pos_inc);
  assign pos_end  = (pos_q == LWB'(LW - 1));

  // packet ends at the end-of-packet bit or at the last word of the line
  assign fetch_fin = ram_rdata[EOP_BIT] || pos_end;

  spm_merge u_merge (
    .mode_i (mode_q),
    .lane_i (lane_q),
    .data_i (data_q),
    .old_i  (ram_rdata),
    .res_o  (mrg)
  );

  spm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = in_widx;
    ram_wdata = write_data_i;
    valid_d   = 1'b0;
    rdata_d   = rdata_q;
    last_d    = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (mode_i) inside
            MODE_STW: begin
              // full word store needs no old value
              ram_en = 1'b1;
              ram_we = 1'b1;
            end
            MODE_LDW, MODE_LDH, MODE_LDB, MODE_STH, MODE_STB,
            MODE_ADD, MODE_OR, MODE_AND, MODE_XOR, MODE_XCHG: begin
              ram_en  = 1'b1;
              state_d = ST_RMW;
            end
            MODE_FETCH: begin
              ram_en  = 1'b1;
              pos_d   = in_ext[LWB-1:0];
              state_d = ST_FETCH;
            end
            MODE_FILL: begin
              pos_d   = '0;
              state_d = ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW: begin
        // old word is on the ram output; merge and write back
        ram_addr  = widx_q;
        ram_en    = mrg.we;
        ram_we    = mrg.we;
        ram_wdata = mrg.wdata;
        valid_d   = mrg.reply;
        rdata_d   = mrg.rdata;
        last_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_FETCH: begin
        valid_d = 1'b1;
        rdata_d = ram_rdata;
        last_d  = fetch_fin;
        if (fetch_fin) begin
          state_d = ST_IDLE;
        end else begin
          ram_en   = 1'b1;
          ram_addr = next_ext[IW-1:0];
          pos_d    = pos_inc;
        end
      end
      ST_FILL: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = line_ext[IW-1:0];
        ram_wdata = data_q;
        if (pos_end) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  // request and reply payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      lane_q <= address_i[1:0];
      widx_q <= in_widx;
      data_q <= write_data_i;
      chan_q <= return_channel_i;
    end
    if (valid_d) begin
      rchan_q <= chan_q;
    end
    rdata_q <= rdata_d;
    last_q  <= last_d;
  end

  assign valid_o         = valid_q;
  assign read_data_o     = rdata_q;
  assign reply_channel_o = rchan_q;
  assign last_o          = last_q;

  // a reply only ever comes from a merge step or a packet word
  `SPM_ASSERT_IMP(a_reply_src, clk_i, rst_ni, valid_q,
                  ($past(state_q) == ST_RMW) || ($past(state_q) == ST_FETCH))
  // every packet fetch cycle yields a reply transfer
  `SPM_ASSERT_NXT(a_fetch_reply, clk_i, rst_ni, state_q == ST_FETCH, valid_q)
  // an unfinished packet keeps fetching
  `SPM_ASSERT_NXT(a_fetch_cont, clk_i, rst_ni,
                  (state_q == ST_FETCH) && !fetch_fin, state_q == ST_FETCH)
  // a line fill request enters the fill sweep
  `SPM_ASSERT_NXT(a_fill_go, clk_i, rst_ni, accept && (mode_i == MODE_FILL),
                  (state_q == ST_FILL) && (pos_q == '0))

endmodule

// File: src/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/spm_merge.sv
// ----------------------------------------------------------------------------
// spm_merge
// lane extraction and combine logic for loads, partial stores and atomics
// ----------------------------------------------------------------------------
module spm_merge import spm_pkg::*; (
  input  logic [MODE_W-1:0] mode_i,
  input  logic [1:0]        lane_i,
  input  logic [WORD_W-1:0] data_i,
  input  logic [WORD_W-1:0] old_i,
  output merge_t            res_o
);

  logic [4:0]        hsh;
  logic [4:0]        bsh;
  logic [WORD_W-1:0] old_h;
  logic [WORD_W-1:0] old_b;

  assign hsh   = {lane_i[1], 4'b0000};
  assign bsh   = {lane_i, 3'b000};
  assign old_h = old_i >> hsh;
  assign old_b = old_i >> bsh;

  always_comb begin
    res_o.we    = 1'b0;
    res_o.reply = 1'b0;
    res_o.wdata = old_i;
    res_o.rdata = old_i;
    unique case (mode_i) inside
      MODE_LDW: begin
        res_o.reply = 1'b1;
      end
      MODE_LDH: begin
        res_o.reply = 1'b1;
        res_o.rdata = {16'h0000, old_h[15:0]};
      end
      MODE_LDB: begin
        res_o.reply = 1'b1;
        res_o.rdata = {24'h000000, old_b[7:0]};
      end
      MODE_STH: begin
        res_o.we    = 1'b1;
        res_o.wdata = (old_i & ~(32'h0000_FFFF << hsh)) |
                      ({16'h0000, data_i[15:0]} << hsh);
      end
      MODE_STB: begin
        res_o.we    = 1'b1;
        res_o.wdata = (old_i & ~(32'h0000_00FF << bsh)) |
                      ({24'h000000, data_i[7:0]} << bsh);
      end
      MODE_ADD: begin
        res_o.we    = 1'b1;
        res_o.reply = 1'b1;
        res_o.wdata = old_i + data_i;
      end
      MODE_OR: begin
        res_o.we    = 1'b1;
        res_o.reply = 1'b1;
        res_o.wdata = old_i | data_i;
      end
      MODE_AND: begin
        res_o.we    = 1'b1;
        res_o.reply = 1'b1;
        res_o.wdata = old_i & data_i;
      end
      MODE_XOR: begin
        res_o.we    = 1'b1;
        res_o.reply = 1'b1;
        res_o.wdata = old_i ^ data_i;
      end
      MODE_XCHG: begin
        res_o.we    = 1'b1;
        res_o.reply = 1'b1;
        res_o.wdata = data_i;
      end
      default: begin
      end
    endcase
  end

endmodule
